@@ design/jdn_pkg.sv @@
// ---------------------------------------------------------------------------
// jdn_pkg
// shared types and constants for the joystick dead zone normaliser
// ---------------------------------------------------------------------------
package jdn_pkg;

    localparam int AXIS_LIMIT   = 25600;
    localparam int REG_W        = 15;
    localparam int AXIS_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int NUM_W        = 31;
    localparam int LANES        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;

    localparam logic [REG_W-1:0] DEAD_ZONE_RST  = 15'd2560;
    localparam logic [REG_W-1:0] FULL_SCALE_RST = 15'd25600;

    typedef struct packed {
        logic valid;
        logic centered;
        logic mag_full;
        logic neg_x;
        logic neg_y;
    } t_side;

endpackage

@@ design/jdn_front.sv @@
// ---------------------------------------------------------------------------
// jdn_front
// saturation, dead zone, squares and set-up of the three root lanes
// ---------------------------------------------------------------------------
module jdn_front #(
    parameter int F = 14,
    parameter int W = 2 * F + 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [jdn_pkg::AXIS_W-1:0]    i_x_tilt,
    input  logic signed [jdn_pkg::AXIS_W-1:0]    i_y_tilt,
    input  logic [jdn_pkg::REG_W-1:0]            i_dead_zone,
    input  logic [jdn_pkg::REG_W-1:0]            i_full_scale,
    output jdn_pkg::t_side                       o_side,
    output logic [jdn_pkg::LANES-1:0][W-1:0]     o_r,
    output logic [jdn_pkg::LANES-1:0][W-1:0]     o_den
);

    localparam logic signed [jdn_pkg::AXIS_W-1:0] LIM = 16'(jdn_pkg::AXIS_LIMIT);

    jdn_pkg::t_side                  r_a_side, r_b_side, r_c_side;
    logic [jdn_pkg::REG_W-1:0]       r_ax, r_ay, r_fs;
    logic [2*jdn_pkg::REG_W-1:0]     r_sqx, r_sqy, r_fs2;
    logic [jdn_pkg::LANES-1:0][W-1:0] r_r, r_den;

    logic signed [jdn_pkg::AXIS_W-1:0] sx, sy;
    logic [jdn_pkg::REG_W-1:0]       abx, aby, dx, dy;
    logic [jdn_pkg::NUM_W-1:0]       len2;

    always_comb begin
        sx = (i_x_tilt > LIM) ? LIM : ((i_x_tilt < -LIM) ? -LIM : i_x_tilt);
        sy = (i_y_tilt > LIM) ? LIM : ((i_y_tilt < -LIM) ? -LIM : i_y_tilt);
        abx = sx[jdn_pkg::AXIS_W-1] ? 15'(-sx) : 15'(sx);
        aby = sy[jdn_pkg::AXIS_W-1] ? 15'(-sy) : 15'(sy);
        dx = (abx > i_dead_zone) ? abx : '0;
        dy = (aby > i_dead_zone) ? aby : '0;
        len2 = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
        end else if (i_en) begin
            r_a_side <= '{valid:    i_valid,
                          centered: (dx == '0) && (dy == '0),
                          mag_full: 1'b0,
                          neg_x:    sy[jdn_pkg::AXIS_W-1] && (dy != '0),
                          neg_y:    !sx[jdn_pkg::AXIS_W-1] && (dx != '0)};
            r_b_side <= r_a_side;
            r_c_side <= '{valid:    r_b_side.valid,
                          centered: r_b_side.centered,
                          mag_full: ({1'b0, r_fs2} <= len2),
                          neg_x:    r_b_side.neg_x,
                          neg_y:    r_b_side.neg_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= dx;
            r_ay  <= dy;
            r_fs  <= (i_full_scale == '0) ? 15'd1 : i_full_scale;
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_fs2 <= r_fs * r_fs;
            r_r[0]   <= W'({1'b0, r_sqy}) << (2 * F);
            r_r[1]   <= W'({1'b0, r_sqx}) << (2 * F);
            r_r[2]   <= W'(len2) << (2 * F);
            r_den[0] <= W'(len2);
            r_den[1] <= W'(len2);
            r_den[2] <= W'({1'b0, r_fs2});
        end
    end

    assign o_side = r_c_side;
    assign o_r    = r_r;
    assign o_den  = r_den;

endmodule

@@ design/jdn_root_cell.sv @@
// ---------------------------------------------------------------------------
// jdn_root_cell
// one bit of three ratio square roots, restoring step without multipliers
// ---------------------------------------------------------------------------
module jdn_root_cell #(
    parameter int F   = 14,
    parameter int BIT = 14,
    parameter int W   = 2 * F + 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  jdn_pkg::t_side                       i_side,
    input  logic [jdn_pkg::LANES-1:0][W-1:0]     i_r,
    input  logic [jdn_pkg::LANES-1:0][W-1:0]     i_dq,
    input  logic [jdn_pkg::LANES-1:0][W-1:0]     i_den,
    input  logic [jdn_pkg::LANES-1:0][F:0]       i_q,
    output jdn_pkg::t_side                       o_side,
    output logic [jdn_pkg::LANES-1:0][W-1:0]     o_r,
    output logic [jdn_pkg::LANES-1:0][W-1:0]     o_dq,
    output logic [jdn_pkg::LANES-1:0][W-1:0]     o_den,
    output logic [jdn_pkg::LANES-1:0][F:0]       o_q
);

    jdn_pkg::t_side                   r_side;
    logic [jdn_pkg::LANES-1:0][W-1:0] r_r, r_dq, r_den, n_r, n_dq;
    logic [jdn_pkg::LANES-1:0][F:0]   r_q, n_q;
    logic [jdn_pkg::LANES-1:0][W:0]   trial;

    always_comb begin
        for (int l = 0; l < jdn_pkg::LANES; l++) begin
            trial[l] = {1'b0, i_dq[l] << (BIT + 1)} + {1'b0, i_den[l] << (2 * BIT)};
            n_r[l]   = i_r[l];
            n_dq[l]  = i_dq[l];
            n_q[l]   = i_q[l];
            if ({1'b0, i_r[l]} >= trial[l]) begin
                n_r[l]    = i_r[l] - trial[l][W-1:0];
                n_dq[l]   = i_dq[l] + (i_den[l] << BIT);
                n_q[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= n_r;
            r_dq  <= n_dq;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_side = r_side;
    assign o_r    = r_r;
    assign o_dq   = r_dq;
    assign o_den  = r_den;
    assign o_q    = r_q;

endmodule

@@ design/joystick_deadzone_normalizer_core.sv @@
// ---------------------------------------------------------------------------
// joystick_deadzone_normalizer_core
// dead zone, unit direction and capped magnitude of a stick sample
// ---------------------------------------------------------------------------
// One transaction is accepted every cycle unless a result is stalled. There
// are three front stages (saturation and dead zone, squares, length), one
// cell per result bit computing the three square roots side by side, and an
// output register. The whole pipeline halts while a result is stalled.
// ---------------------------------------------------------------------------
module joystick_deadzone_normalizer_core #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [jdn_pkg::AXIS_W-1:0]      i_x_tilt,
    input  logic signed [jdn_pkg::AXIS_W-1:0]      i_y_tilt,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [OUT_FRAC_BITS+1:0]        o_dir_x,
    output logic signed [OUT_FRAC_BITS+1:0]        o_dir_y,
    output logic [OUT_FRAC_BITS:0]                 o_magnitude,
    output logic                                   o_centered,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [jdn_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [jdn_pkg::REG_W-1:0]              i_cfg_data
);

    localparam int F = OUT_FRAC_BITS;
    localparam int W = 2 * F + 32;
    localparam int N = F + 1;

    logic                                       en;
    logic [jdn_pkg::REG_W-1:0]                  r_dead_zone, r_full_scale;
    jdn_pkg::t_side                             side [N+1];
    logic [jdn_pkg::LANES-1:0][W-1:0]           rr [N+1];
    logic [jdn_pkg::LANES-1:0][W-1:0]           dq [N+1];
    logic [jdn_pkg::LANES-1:0][W-1:0]           den [N+1];
    logic [jdn_pkg::LANES-1:0][F:0]             q [N+1];
    logic                                       r_valid, r_centered;
    logic signed [F+1:0]                        r_dir_x, r_dir_y;
    logic [F:0]                                 r_mag;

    assign en          = !(r_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= jdn_pkg::DEAD_ZONE_RST;
            r_full_scale <= jdn_pkg::FULL_SCALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jdn_pkg::CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data;
                jdn_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    jdn_front #(.F(F), .W(W)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_x_tilt     (i_x_tilt),
        .i_y_tilt     (i_y_tilt),
        .i_dead_zone  (r_dead_zone),
        .i_full_scale (r_full_scale),
        .o_side       (side[0]),
        .o_r          (rr[0]),
        .o_den        (den[0])
    );

    assign dq[0] = '0;
    assign q[0]  = '0;

    for (genvar s = 0; s < N; s++) begin : g_cell
        jdn_root_cell #(.F(F), .BIT(F - s), .W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (side[s]),
            .i_r     (rr[s]),
            .i_dq    (dq[s]),
            .i_den   (den[s]),
            .i_q     (q[s]),
            .o_side  (side[s+1]),
            .o_r     (rr[s+1]),
            .o_dq    (dq[s+1]),
            .o_den   (den[s+1]),
            .o_q     (q[s+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= side[N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_centered <= side[N].centered;
            if (side[N].centered) begin
                r_dir_x <= '0;
                r_dir_y <= '0;
                r_mag   <= '0;
            end else begin
                r_dir_x <= side[N].neg_x ? -$signed({1'b0, q[N][0]}) : $signed({1'b0, q[N][0]});
                r_dir_y <= side[N].neg_y ? -$signed({1'b0, q[N][1]}) : $signed({1'b0, q[N][1]});
                r_mag   <= side[N].mag_full ? (F+1)'(1) << F : q[N][2];
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_dir_x     = r_dir_x;
    assign o_dir_y     = r_dir_y;
    assign o_magnitude = r_mag;
    assign o_centered  = r_centered;

    a_centered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_centered |-> o_dir_x == '0 && o_dir_y == '0 && o_magnitude == '0)
        else $error("centered result carries non-zero fields");

    a_mag_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_magnitude <= ((F+1)'(1) << F))
        else $error("magnitude above full scale");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_magnitude) && $stable(o_dir_x))
        else $error("stalled result changed");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall out of step with output");

endmodule
